### rtl/stxr_pkg.sv
// ----------------------------------------------------------------------------
// stxr_pkg
// Types and codes shared by the STX / length / XOR frame receiver.
// ----------------------------------------------------------------------------
package stxr_pkg;

  localparam logic [7:0]  START_BYTE    = 8'h02;
  localparam logic [7:0]  DROP_LENGTH   = 8'hFF;
  localparam logic [15:0] RESET_TIMEOUT = 16'd10;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
  localparam logic [8:0]  HEADER_BYTES  = 9'd3;

  // Configuration register indexes
  localparam logic REG_CHECKSUM_ENABLE = 1'b0;
  localparam logic REG_TIMEOUT_TICKS   = 1'b1;

  // Input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_CMD  = 3'd0;
  localparam logic [2:0] KIND_DATA = 3'd1;
  localparam logic [2:0] KIND_GOOD = 3'd2;
  localparam logic [2:0] KIND_BAD  = 3'd3;
  localparam logic [2:0] KIND_DROP = 3'd4;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic [8:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic        checksum_enable;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

### rtl/stxr_in_reg.sv
// ----------------------------------------------------------------------------
// stxr_in_reg
// Input register stage: holds one item until the core consumes it.
// ----------------------------------------------------------------------------
module stxr_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  stxr_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output stxr_pkg::in_item_t item
);
  import stxr_pkg::*;

  logic load;

  // Hold while the downstream side cannot take the held item
  assign in_stall = item_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

### rtl/stxr_core.sv
// ----------------------------------------------------------------------------
// stxr_core
// Frame state machine: updates frame state and forms at most one result per item.
// ----------------------------------------------------------------------------
module stxr_core (
  input  logic               clk,
  input  logic               rst,
  input  stxr_pkg::cfg_t     cfg,
  input  logic               fire,
  input  stxr_pkg::in_item_t item,
  output logic               res_valid,
  output stxr_pkg::out_item_t res
);
  import stxr_pkg::*;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_CMD     = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CSUM    = 3'd4;
  localparam logic [2:0] PH_REPORT  = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [15:0] idle_count, idle_count_next;

  logic [15:0] idle_inc;
  logic [7:0]  count_inc;
  logic [8:0]  total_length;
  logic        is_start;

  assign idle_inc     = (idle_count == IDLE_MAX) ? idle_count : idle_count + 16'd1;
  assign count_inc    = payload_count + 8'd1;
  assign total_length = {1'b0, payload_length} + HEADER_BYTES;
  assign is_start     = (item.rx_byte == START_BYTE);

  always_comb begin
    phase_next          = phase;
    running_xor_next    = running_xor;
    payload_length_next = payload_length;
    payload_count_next  = payload_count;
    idle_count_next     = idle_count;
    res_valid           = 1'b0;
    res                 = '0;

    if (fire) begin
      if (phase == PH_REPORT) begin
        // Pending frame-good; a byte here is also seen by the hunter
        res_valid         = 1'b1;
        res.kind          = KIND_GOOD;
        res.frame_length  = total_length;
        phase_next        = PH_HUNT;
        if (item.action == ACT_BYTE && is_start) begin
          phase_next       = PH_CMD;
          running_xor_next = START_BYTE;
          idle_count_next  = '0;
        end
      end else if (item.action == ACT_TICK) begin
        if (phase != PH_HUNT) begin
          if (idle_inc >= cfg.timeout_ticks) begin
            phase_next      = PH_HUNT;
            idle_count_next = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_DROP;
          end else begin
            idle_count_next = idle_inc;
          end
        end
      end else begin
        idle_count_next = '0;
        unique case (phase)
          PH_CMD: begin
            running_xor_next = running_xor ^ item.rx_byte;
            phase_next       = PH_LEN;
            res_valid        = 1'b1;
            res.kind         = KIND_CMD;
            res.byte_value   = item.rx_byte;
          end
          PH_LEN: begin
            running_xor_next    = running_xor ^ item.rx_byte;
            payload_length_next = item.rx_byte;
            payload_count_next  = '0;
            if (item.rx_byte == DROP_LENGTH) begin
              phase_next = PH_HUNT;
              res_valid  = 1'b1;
              res.kind   = KIND_DROP;
            end else if (item.rx_byte == 8'd0) begin
              if (cfg.checksum_enable) begin
                phase_next = PH_CSUM;
              end else begin
                phase_next       = PH_HUNT;
                res_valid        = 1'b1;
                res.kind         = KIND_GOOD;
                res.frame_length = HEADER_BYTES;
              end
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            running_xor_next   = running_xor ^ item.rx_byte;
            payload_count_next = count_inc;
            if (count_inc == payload_length) begin
              phase_next = cfg.checksum_enable ? PH_CSUM : PH_REPORT;
            end
            res_valid      = 1'b1;
            res.kind       = KIND_DATA;
            res.byte_value = item.rx_byte;
          end
          PH_CSUM: begin
            phase_next       = PH_HUNT;
            res_valid        = 1'b1;
            res.kind         = (item.rx_byte == running_xor) ? KIND_GOOD : KIND_BAD;
            res.frame_length = total_length;
          end
          default: begin
            phase_next = PH_HUNT;
            if (is_start) begin
              phase_next       = PH_CMD;
              running_xor_next = START_BYTE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      running_xor    <= '0;
      payload_length <= '0;
      payload_count  <= '0;
      idle_count     <= '0;
    end else begin
      phase          <= phase_next;
      running_xor    <= running_xor_next;
      payload_length <= payload_length_next;
      payload_count  <= payload_count_next;
      idle_count     <= idle_count_next;
    end
  end

endmodule

### rtl/stxr_out_reg.sv
// ----------------------------------------------------------------------------
// stxr_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module stxr_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  stxr_pkg::out_item_t res,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output stxr_pkg::out_item_t out_item
);
  import stxr_pkg::*;

  // Free when empty or being drained this cycle
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      out_item <= res;
    end
  end

endmodule

### rtl/stx_length_xor_frame_receiver.sv
// ----------------------------------------------------------------------------
// stx_length_xor_frame_receiver
// STX / command / length / payload / XOR checksum deframer.
// ----------------------------------------------------------------------------
// Each input item is either a received byte or one time tick. The receiver
// hunts for the start byte 0x02, then takes a command byte, a length byte
// (255 drops the frame), that many payload bytes and, when checksum_enable
// is set, a trailing checksum byte equal to the XOR of all frame bytes from
// the start byte on. It reports the command (kind 0), each payload byte
// (kind 1) and a final status: frame good (2), checksum mismatch (3) with
// the length plus 3, or frame dropped (4). timeout_ticks idle ticks inside a
// frame abort it with kind 4. With checking off, frame good follows on the
// item after the last payload byte, or comes with a length byte of 0.
// The block takes one item every cycle while in_stall is low. An accepted
// item is held in the input register; the frame state update then forms its
// result, if any, into the result register, which holds it until taken.
// in_stall rises only while the result register is full and stalled.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module stx_length_xor_frame_receiver (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  stxr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output stxr_pkg::out_item_t out_item,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import stxr_pkg::*;

  cfg_t      cfg;
  logic      advance;
  logic      item_valid;
  in_item_t  item;
  logic      fire;
  logic      res_valid;
  out_item_t res;

  // Configuration registers, written directly from the port
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.checksum_enable <= 1'b1;
      cfg.timeout_ticks   <= RESET_TIMEOUT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHECKSUM_ENABLE: cfg.checksum_enable <= cfg_data[0];
        REG_TIMEOUT_TICKS:   cfg.timeout_ticks   <= cfg_data;
        default:             cfg                 <= cfg;
      endcase
    end
  end

  // Input stage: accept an item whenever the held one can move on
  stxr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Advance the frame state only when the result register can take a result
  assign fire = item_valid && advance;

  stxr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result stage: holds a result while the consumer stalls; the stall reaches the input side only when it is full
  stxr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### rtl/stxr_checker.sv
// ----------------------------------------------------------------------------
// stxr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module stxr_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input stxr_pkg::out_item_t out_item
);
  import stxr_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Input backpressure only comes from a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Status results carry no byte and at least the header length
  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == KIND_GOOD || out_item.kind == KIND_BAD)
      |-> out_item.byte_value == 8'd0 && out_item.frame_length >= HEADER_BYTES)
    else $error("bad status result fields");

  // Byte results and drops carry no length
  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == KIND_CMD || out_item.kind == KIND_DATA ||
                  out_item.kind == KIND_DROP)
      |-> out_item.frame_length == 9'd0)
    else $error("length on a non-status result");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stx_length_xor_frame_receiver stxr_checker u_stxr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
